### sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CFGA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CFGA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/cfga_pkg.sv
`default_nettype none
package cfga_pkg;

  localparam int GRID_DIM  = 16;
  localparam int ROW_W     = $clog2(GRID_DIM);
  localparam int FACES     = 6;
  localparam int FACE_W    = 3;
  localparam int MAX_CUBES = 8;
  localparam int CNT_W     = 4;
  localparam int SIZE_W    = 11;
  localparam int SPAN_W    = 3;
  localparam int RES_W     = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_EVAL, S_MARK_RD, S_MARK_WR, S_UNDO_RD, S_UNDO_WR, S_OUT, S_STAT
  } state_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_BADSIZE = 2'd3
  } status_t;

  typedef struct packed {
    logic                clr;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [GRID_DIM-1:0] wr_data;
  } mem_req_t;

  // clamp to 256..1024 and round to the nearest power of two, ties upward
  function automatic logic [SIZE_W-1:0] snap_size(input logic [RES_W-1:0] want);
    logic [SIZE_W-1:0] s;
    if (want < RES_W'(384)) begin
      s = SIZE_W'(256);
    end else if (want < RES_W'(768)) begin
      s = SIZE_W'(512);
    end else begin
      s = SIZE_W'(1024);
    end
    return s;
  endfunction

  function automatic logic [GRID_DIM-1:0] span_mask(input logic [SPAN_W-1:0] span);
    return GRID_DIM'((GRID_DIM'(1) << span) - GRID_DIM'(1));
  endfunction

endpackage
`default_nettype wire

### sv/cfga_if.sv
`default_nettype none
interface cfga_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [cfga_pkg::RES_W-1:0] desired_resolution;
  modport source (output valid, output op, output desired_resolution, input ready);
  modport sink (input valid, input op, input desired_resolution, output ready);
endinterface

interface cfga_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [2:0]                  face_index;
  logic [3:0]                  face_cell_x;
  logic [3:0]                  face_cell_y;
  logic [cfga_pkg::SIZE_W-1:0] tile_size;
  logic [2:0]                  cube_number;
  logic                        last;
  modport source (output valid, output status, output face_index, output face_cell_x,
                  output face_cell_y, output tile_size, output cube_number, output last,
                  input ready);
  modport sink (input valid, input status, input face_index, input face_cell_x,
                input face_cell_y, input tile_size, input cube_number, input last,
                output ready);
endinterface
`default_nettype wire

### sv/cfga_grid_mem.sv
`default_nettype none
module cfga_grid_mem (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cfga_pkg::mem_req_t              req,
  output logic [cfga_pkg::GRID_DIM-1:0]        rd_data
);

  logic [cfga_pkg::GRID_DIM-1:0] mem [cfga_pkg::GRID_DIM];
  logic [cfga_pkg::GRID_DIM-1:0] row_vld_r;
  logic [cfga_pkg::GRID_DIM-1:0] rd_q_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // a row never written since the last clear reads as free
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

### sv/cfga_ctrl.sv
`default_nettype none
module cfga_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [cfga_pkg::CNT_W-1:0]      limit,
  cfga_in_if.sink                              in_if,
  cfga_out_if.source                           out_if,
  output cfga_pkg::mem_req_t                   mem_req,
  input  wire logic [cfga_pkg::GRID_DIM-1:0]   rd_data
);

  localparam int GD = cfga_pkg::GRID_DIM;
  localparam int RW = cfga_pkg::ROW_W;
  localparam int FW = cfga_pkg::FACE_W;

  cfga_pkg::state_t  state_r, state_nxt;
  cfga_pkg::status_t stat_r, stat_nxt;
  logic [cfga_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [cfga_pkg::SPAN_W-1:0] span_r, span_nxt;
  logic [RW-1:0]  y_r, y_nxt;
  logic [RW-1:0]  x_r, x_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [1:0]     row_r, row_nxt;
  logic [GD-1:0]  acc_r, acc_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic [FW-1:0]  face_r, face_nxt;
  logic [FW-1:0]  undo_r, undo_nxt;
  logic [FW-1:0]  o_r, o_nxt;
  logic [cfga_pkg::CNT_W-1:0] cubes_r, cubes_nxt;
  logic [RW-1:0]  px_r [cfga_pkg::FACES];
  logic [RW-1:0]  py_r [cfga_pkg::FACES];
  logic           place_we;

  logic                        out_valid_r, out_valid_nxt;
  cfga_pkg::status_t           out_status_r, out_status_nxt;
  logic [2:0]                  out_face_r, out_face_nxt;
  logic [3:0]                  out_x_r, out_x_nxt;
  logic [3:0]                  out_y_r, out_y_nxt;
  logic [cfga_pkg::SIZE_W-1:0] out_size_r, out_size_nxt;
  logic [2:0]                  out_cube_r, out_cube_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [GD-1:0]  acc_full;
  logic [GD-1:0]  spm;
  logic [GD-1:0]  free_x;
  logic           fit_any;
  logic [RW-1:0]  fit_x;
  logic           scan_last, y_more, row_last, face_last, undo_last, o_last;
  logic           in_fire, out_load, at_limit;
  logic [cfga_pkg::CNT_W-1:0] lim_eff;
  logic [RW-1:0]  ux, uy;
  logic [GD-1:0]  mark_mask, undo_mask;
  logic [cfga_pkg::SIZE_W-1:0] snapped;

  assign in_if.ready = (state_r == cfga_pkg::S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = !out_valid_r || out_if.ready;

  assign lim_eff  = (limit < cfga_pkg::CNT_W'(cfga_pkg::MAX_CUBES)) ? limit
                    : cfga_pkg::CNT_W'(cfga_pkg::MAX_CUBES);
  assign at_limit = (cubes_r >= lim_eff);
  assign snapped  = cfga_pkg::snap_size(in_if.desired_resolution);

  assign acc_full  = acc_r | (rd_pend_r ? rd_data : '0);
  assign spm       = cfga_pkg::span_mask(span_r);
  assign scan_last = ({1'b0, cnt_r} == span_r - 3'd1);
  assign row_last  = ({1'b0, row_r} == span_r - 3'd1);
  assign y_more    = ({1'b0, y_r} + {2'b0, span_r}) < 5'(GD);
  assign face_last = (face_r == FW'(cfga_pkg::FACES - 1));
  assign undo_last = (undo_r == face_r - FW'(1));
  assign o_last    = (o_r == FW'(cfga_pkg::FACES - 1));
  assign ux        = px_r[undo_r];
  assign uy        = py_r[undo_r];
  assign mark_mask = GD'(spm << x_r);
  assign undo_mask = GD'(spm << ux);

  // windows of span free columns in the or of the candidate rows
  always_comb begin
    for (int x = 0; x < GD; x++) begin
      free_x[x] = ((5'(x) + {2'b0, span_r}) <= 5'(GD)) &&
                  ((GD'(acc_full >> x) & spm) == '0);
    end
  end

  always_comb begin
    fit_x = '0;
    for (int x = GD - 1; x >= 0; x--) begin
      if (free_x[x]) begin
        fit_x = RW'(x);
      end
    end
  end
  assign fit_any = |free_x;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfga_pkg::S_IDLE: begin
        if (in_fire && in_if.op) begin
          state_nxt = at_limit ? cfga_pkg::S_STAT : cfga_pkg::S_SCAN;
        end
      end
      cfga_pkg::S_SCAN: begin
        if (scan_last) state_nxt = cfga_pkg::S_EVAL;
      end
      cfga_pkg::S_EVAL: begin
        if (fit_any) begin
          state_nxt = cfga_pkg::S_MARK_RD;
        end else if (y_more) begin
          state_nxt = cfga_pkg::S_SCAN;
        end else if (face_r == '0) begin
          state_nxt = cfga_pkg::S_STAT;
        end else begin
          state_nxt = cfga_pkg::S_UNDO_RD;
        end
      end
      cfga_pkg::S_MARK_RD: state_nxt = cfga_pkg::S_MARK_WR;
      cfga_pkg::S_MARK_WR: begin
        if (!row_last) begin
          state_nxt = cfga_pkg::S_MARK_RD;
        end else if (face_last) begin
          state_nxt = cfga_pkg::S_OUT;
        end else begin
          state_nxt = cfga_pkg::S_SCAN;
        end
      end
      cfga_pkg::S_UNDO_RD: state_nxt = cfga_pkg::S_UNDO_WR;
      cfga_pkg::S_UNDO_WR: begin
        if (row_last && undo_last) begin
          state_nxt = cfga_pkg::S_STAT;
        end else begin
          state_nxt = cfga_pkg::S_UNDO_RD;
        end
      end
      cfga_pkg::S_OUT: begin
        if (out_load && o_last) state_nxt = cfga_pkg::S_IDLE;
      end
      cfga_pkg::S_STAT: begin
        if (out_load) state_nxt = cfga_pkg::S_IDLE;
      end
      default: state_nxt = cfga_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    stat_nxt    = stat_r;
    size_nxt    = size_r;
    span_nxt    = span_r;
    y_nxt       = y_r;
    x_nxt       = x_r;
    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    acc_nxt     = acc_r;
    rd_pend_nxt = 1'b0;
    face_nxt    = face_r;
    undo_nxt    = undo_r;
    o_nxt       = o_r;
    cubes_nxt   = cubes_r;
    place_we    = 1'b0;
    mem_req     = '0;

    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_face_nxt   = out_face_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_size_nxt   = out_size_r;
    out_cube_nxt   = out_cube_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      cfga_pkg::S_IDLE: begin
        if (in_fire) begin
          if (!in_if.op) begin
            mem_req.clr = 1'b1;
            cubes_nxt   = '0;
          end else if (at_limit) begin
            stat_nxt = cfga_pkg::ST_LIMIT;
            size_nxt = '0;
          end else begin
            size_nxt = snapped;
            span_nxt = snapped[10:8];
            face_nxt = '0;
            y_nxt    = '0;
            cnt_nxt  = '0;
            acc_nxt  = '0;
          end
        end
      end
      cfga_pkg::S_SCAN: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = y_r + RW'(cnt_r);
        rd_pend_nxt     = 1'b1;
        acc_nxt         = acc_full;
        cnt_nxt         = scan_last ? 2'd0 : cnt_r + 2'd1;
      end
      cfga_pkg::S_EVAL: begin
        acc_nxt = '0;
        if (fit_any) begin
          x_nxt   = fit_x;
          row_nxt = '0;
        end else if (y_more) begin
          y_nxt = y_r + RW'(1);
        end else if (face_r == '0) begin
          stat_nxt = cfga_pkg::ST_NOFIT;
        end else begin
          undo_nxt = '0;
          row_nxt  = '0;
        end
      end
      cfga_pkg::S_MARK_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = y_r + RW'(row_r);
      end
      cfga_pkg::S_MARK_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = y_r + RW'(row_r);
        mem_req.wr_data = rd_data | mark_mask;
        row_nxt         = row_r + 2'd1;
        if (row_last) begin
          row_nxt  = '0;
          place_we = 1'b1;
          face_nxt = face_r + FW'(1);
          y_nxt    = '0;
          o_nxt    = '0;
        end
      end
      cfga_pkg::S_UNDO_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = uy + RW'(row_r);
      end
      cfga_pkg::S_UNDO_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = uy + RW'(row_r);
        mem_req.wr_data = rd_data & ~undo_mask;
        row_nxt         = row_r + 2'd1;
        if (row_last) begin
          row_nxt  = '0;
          undo_nxt = undo_r + FW'(1);
          stat_nxt = cfga_pkg::ST_NOFIT;
        end
      end
      cfga_pkg::S_OUT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cfga_pkg::ST_OK;
          out_face_nxt   = o_r;
          out_x_nxt      = px_r[o_r];
          out_y_nxt      = py_r[o_r];
          out_size_nxt   = size_r;
          out_cube_nxt   = cubes_r[2:0];
          out_last_nxt   = o_last;
          o_nxt          = o_r + FW'(1);
          if (o_last) cubes_nxt = cubes_r + cfga_pkg::CNT_W'(1);
        end
      end
      cfga_pkg::S_STAT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_face_nxt   = '0;
          out_x_nxt      = '0;
          out_y_nxt      = '0;
          out_size_nxt   = size_r;
          out_cube_nxt   = '0;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfga_pkg::S_IDLE;
      cubes_r     <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cubes_r     <= cubes_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r       <= stat_nxt;
    size_r       <= size_nxt;
    span_r       <= span_nxt;
    y_r          <= y_nxt;
    x_r          <= x_nxt;
    cnt_r        <= cnt_nxt;
    row_r        <= row_nxt;
    acc_r        <= acc_nxt;
    face_r       <= face_nxt;
    undo_r       <= undo_nxt;
    o_r          <= o_nxt;
    out_status_r <= out_status_nxt;
    out_face_r   <= out_face_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_size_r   <= out_size_nxt;
    out_cube_r   <= out_cube_nxt;
    out_last_r   <= out_last_nxt;
    if (place_we) begin
      px_r[face_r] <= x_r;
      py_r[face_r] <= y_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.face_index  = out_face_r;
  assign out_if.face_cell_x = out_x_r;
  assign out_if.face_cell_y = out_y_r;
  assign out_if.tile_size   = out_size_r;
  assign out_if.cube_number = out_cube_r;
  assign out_if.last        = out_last_r;

endmodule
`default_nettype wire

### sv/cube_face_tile_grid_allocator_unit.sv
// channel   dir  handshake        payload
// in_if     in   valid / ready    op, desired_resolution
// out_if    out  valid / ready    status, face_index, face_cell_x, face_cell_y,
//                                 tile_size, cube_number, last
// cfg       in   cfg_wr_en        cfg_wr_data (cube_limit)
//
// a clear leaves the unit idle; a limit hit goes through S_STAT to the output handoff
// a request scans, per face and per candidate row, span rows in S_SCAN, then S_EVAL
// (single read port of the row memory), then reads and rewrites each row it marks;
// six results then leave one per cycle while out_if.ready is high
// rollback after a failed face rewrites the rows of each face already placed
// reset clears the row valid bits at once, no sweep; input is taken only when idle
`default_nettype none
module cube_face_tile_grid_allocator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [cfga_pkg::CNT_W-1:0]  cfg_wr_data,
  cfga_in_if.sink                          in_if,
  cfga_out_if.source                       out_if
);

  logic [cfga_pkg::CNT_W-1:0]    limit_r;
  cfga_pkg::mem_req_t            mem_req;
  logic [cfga_pkg::GRID_DIM-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cfga_pkg::CNT_W'(cfga_pkg::MAX_CUBES);
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  cfga_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .limit   (limit_r),
    .in_if   (in_if),
    .out_if  (out_if),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  cfga_grid_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

### sv/cfga_checker.sv
`default_nettype none
`include "assert_macros.svh"
module cfga_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [2:0] out_face_index,
  input wire logic       out_last
);

  `CFGA_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result valid right after reset")
  `CFGA_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_status), "stalled result changed")
  `CFGA_ASSERT(a_err_last, out_valid && out_status != cfga_pkg::ST_OK |-> out_last, "status result not last")
  `CFGA_ASSERT(a_ok_last_face, out_valid && out_status == cfga_pkg::ST_OK && out_last |-> out_face_index == 3'(cfga_pkg::FACES - 1), "last face index wrong")

endmodule

bind cube_face_tile_grid_allocator_unit cfga_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_status     (out_if.status),
  .out_face_index (out_if.face_index),
  .out_last       (out_if.last)
);
`default_nettype wire
